@@ hdl/iprt_pkg.sv @@
`default_nettype none

package iprt_pkg;

    // Fixed field widths
    localparam int ADDR_W      = 32;
    localparam int IFACE_W     = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    // Slave-side tdata layout, lowest bit first
    localparam int S_NET_LSB   = 0;
    localparam int S_MASK_LSB  = S_NET_LSB + ADDR_W;
    localparam int S_GW_LSB    = S_MASK_LSB + ADDR_W;
    localparam int S_IFACE_LSB = S_GW_LSB + ADDR_W;
    localparam int S_ADDR_LSB  = S_IFACE_LSB + IFACE_W;
    localparam int S_FIELDS_W  = S_ADDR_LSB + ADDR_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;

    // Item kind carried on s_tuser
    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_VALID = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_GW    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_IFACE = 2'd2;

    typedef enum logic [1:0] {
        ST_ADDED   = 2'd0,
        ST_FULL    = 2'd1,
        ST_FOUND   = 2'd2,
        ST_UNREACH = 2'd3
    } status_t;

    // Control part of the token handed from cell to cell
    typedef struct packed {
        logic valid;
        logic is_add;
        logic full;
        logic found;
    } tok_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/iprt_cell.sv @@
`default_nettype none

module iprt_cell import iprt_pkg::*; #(
    parameter int ROUTE_ENTRIES = 16,
    parameter int CELL_IDX      = 0,
    localparam int IDX_W        = $clog2(ROUTE_ENTRIES + 1)
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               adv,
    input  wire logic               wr_req,
    input  wire logic [IDX_W-1:0]   count,
    input  wire logic [ADDR_W-1:0]  wr_network,
    input  wire logic [ADDR_W-1:0]  wr_mask,
    input  wire logic [ADDR_W-1:0]  wr_gateway,
    input  wire logic [IFACE_W-1:0] wr_iface,
    input  wire tok_ctrl_t          ctrl_in,
    input  wire logic [ADDR_W-1:0]  addr_in,
    input  wire logic [ADDR_W-1:0]  hop_in,
    input  wire logic [IFACE_W-1:0] iface_in,
    input  wire logic [IDX_W-1:0]   idx_in,
    output tok_ctrl_t               ctrl_out,
    output logic [ADDR_W-1:0]       addr_out,
    output logic [ADDR_W-1:0]       hop_out,
    output logic [IFACE_W-1:0]      iface_out,
    output logic [IDX_W-1:0]        idx_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [ADDR_W-1:0]  ent_network_reg;
    logic [ADDR_W-1:0]  ent_mask_reg;
    logic [ADDR_W-1:0]  ent_gateway_reg;
    logic [IFACE_W-1:0] ent_iface_reg;

    tok_ctrl_t          ctrl_reg, ctrl_next;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  hop_reg, hop_next;
    logic [IFACE_W-1:0] iface_reg, iface_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               match;

    // Write this slot when an add lands on it
    always_ff @(posedge aclk) begin
        if (wr_req && count == MY_IDX) begin
            ent_network_reg <= wr_network;
            ent_mask_reg    <= wr_mask;
            ent_gateway_reg <= wr_gateway;
            ent_iface_reg   <= wr_iface;
        end
    end

    // First match only: a token already resolved passes untouched
    always_comb begin
        match = ctrl_in.valid && !ctrl_in.is_add && !ctrl_in.found && (MY_IDX < count)
                && ((addr_in & ent_mask_reg) == ent_network_reg);
        ctrl_next       = ctrl_in;
        ctrl_next.found = ctrl_in.found | match;
        hop_next        = hop_in;
        iface_next      = iface_in;
        idx_next        = idx_in;
        if (match) begin
            hop_next   = (ent_gateway_reg != '0) ? ent_gateway_reg : addr_in;
            iface_next = ent_iface_reg;
            idx_next   = MY_IDX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (adv) begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            addr_reg  <= addr_in;
            hop_reg   <= hop_next;
            iface_reg <= iface_next;
            idx_reg   <= idx_next;
        end
    end

    assign ctrl_out  = ctrl_reg;
    assign addr_out  = addr_reg;
    assign hop_out   = hop_reg;
    assign iface_out = iface_reg;
    assign idx_out   = idx_reg;

endmodule

`default_nettype wire

@@ hdl/ipv4_route_table_lookup.sv @@
// IPv4 route table with first-match lookup, one item in flight at a time.
// Input channel s_*: s_tuser selects the item kind (add a route or look up an
// address), s_tdata carries the route fields and the lookup address.
// Result channel m_*: one transaction per input item; m_tuser holds the
// status, m_tdata the next hop, interface and hit index.
// Configuration channel cfg_*: writes the default route registers; always
// ready, and meant to be used only while no item is in flight.
// Every item walks the row of ROUTE_ENTRIES cells, one cell per cycle, each
// cell holding one route and comparing it against the token passing through.
// Adds and lookups alike walk the whole row before their result is loaded
// into the output register; s_tready returns as soon as that result is
// loaded, so a new item is taken only once the last one has left the
// row.
// A stalled receiver holds the finished result in the output register; a new
// item may still be accepted and walks the row until it reaches the end,
// where it waits for the output register to drain.
// Reset empties the table (route count to zero), clears the default route
// and drops any item in flight. No clearing pass is needed.
`default_nettype none

module ipv4_route_table_lookup import iprt_pkg::*; #(
    parameter int ROUTE_ENTRIES = 16,
    localparam int IDX_W        = $clog2(ROUTE_ENTRIES + 1),
    localparam int M_TDATA_W    = ((ADDR_W + IFACE_W + IDX_W + 7) / 8) * 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Input items
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // route_network, route_mask, route_gateway, route_iface, lookup_addr
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    // action
    input  wire logic                   s_tuser,
    // Results
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // next_hop, out_iface, hit_index
    output logic [M_TDATA_W-1:0]        m_tdata,
    // status
    output logic [1:0]                  m_tuser,
    // Configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [IDX_W-1:0] ENTRIES_IDX = IDX_W'(ROUTE_ENTRIES);

    // Configuration registers
    logic               def_valid_reg;
    logic [ADDR_W-1:0]  def_gw_reg;
    logic [IFACE_W-1:0] def_iface_reg;

    // Table and sequencing state
    logic [IDX_W-1:0]   count_reg;
    logic               busy_reg, busy_next;
    logic               s_acc;
    logic               is_add;
    logic               full;
    logic               adv;
    logic               load;

    // Token chain, one slot per cell boundary
    tok_ctrl_t          ch_ctrl  [ROUTE_ENTRIES+1];
    logic [ADDR_W-1:0]  ch_addr  [ROUTE_ENTRIES+1];
    logic [ADDR_W-1:0]  ch_hop   [ROUTE_ENTRIES+1];
    logic [IFACE_W-1:0] ch_iface [ROUTE_ENTRIES+1];
    logic [IDX_W-1:0]   ch_idx   [ROUTE_ENTRIES+1];
    tok_ctrl_t          tail;

    // Result formed at the end of the row
    status_t            res_status;
    logic [ADDR_W-1:0]  res_hop;
    logic [IFACE_W-1:0] res_iface;
    logic [IDX_W-1:0]   res_idx;

    // Output register
    logic               m_valid_reg;
    status_t            m_status_reg;
    logic [ADDR_W-1:0]  m_hop_reg;
    logic [IFACE_W-1:0] m_iface_reg;
    logic [IDX_W-1:0]   m_idx_reg;

    assign s_tready  = !busy_reg;
    assign s_acc     = s_tvalid && s_tready;
    assign is_add    = (s_tuser == ACT_ADD);
    assign full      = (count_reg >= ENTRIES_IDX);
    assign cfg_ready = 1'b1;

    // Configuration writes; unknown indexes fall through untouched
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            def_valid_reg <= 1'b0;
            def_gw_reg    <= '0;
            def_iface_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_DEFAULT_VALID: def_valid_reg <= cfg_data[0];
                CFG_DEFAULT_GW:    def_gw_reg    <= cfg_data[ADDR_W-1:0];
                CFG_DEFAULT_IFACE: def_iface_reg <= cfg_data[IFACE_W-1:0];
                default: ;
            endcase
        end
    end

    // Route count: the add that finds room takes the next slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (s_acc && is_add && !full) begin
            count_reg <= count_reg + IDX_W'(1);
        end
    end

    // Freeze the row only while a finished token faces a full output register
    assign adv  = !(tail.valid && m_valid_reg && !m_tready);
    assign load = tail.valid && adv;

    always_comb begin
        busy_next = busy_reg;
        if (load) begin
            busy_next = 1'b0;
        end
        if (s_acc) begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    // Token entering the first cell; an add carries its slot as the index
    always_comb begin
        ch_ctrl[0].valid  = s_acc;
        ch_ctrl[0].is_add = is_add;
        ch_ctrl[0].full   = full;
        ch_ctrl[0].found  = 1'b0;
        ch_addr[0]        = s_tdata[S_ADDR_LSB +: ADDR_W];
        ch_hop[0]         = '0;
        ch_iface[0]       = '0;
        ch_idx[0]         = (is_add && !full) ? count_reg : ENTRIES_IDX;
    end

    for (genvar g = 0; g < ROUTE_ENTRIES; g++) begin : g_cell
        iprt_cell #(
            .ROUTE_ENTRIES (ROUTE_ENTRIES),
            .CELL_IDX      (g)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .adv        (adv),
            .wr_req     (s_acc && is_add),
            .count      (count_reg),
            .wr_network (s_tdata[S_NET_LSB +: ADDR_W]),
            .wr_mask    (s_tdata[S_MASK_LSB +: ADDR_W]),
            .wr_gateway (s_tdata[S_GW_LSB +: ADDR_W]),
            .wr_iface   (s_tdata[S_IFACE_LSB +: IFACE_W]),
            .ctrl_in    (ch_ctrl[g]),
            .addr_in    (ch_addr[g]),
            .hop_in     (ch_hop[g]),
            .iface_in   (ch_iface[g]),
            .idx_in     (ch_idx[g]),
            .ctrl_out   (ch_ctrl[g+1]),
            .addr_out   (ch_addr[g+1]),
            .hop_out    (ch_hop[g+1]),
            .iface_out  (ch_iface[g+1]),
            .idx_out    (ch_idx[g+1])
        );
    end

    assign tail = ch_ctrl[ROUTE_ENTRIES];

    // Resolve the token: add outcome, route hit, default route or unreachable
    always_comb begin
        res_status = ST_UNREACH;
        res_hop    = '0;
        res_iface  = '0;
        res_idx    = ENTRIES_IDX;
        if (tail.is_add) begin
            res_status = tail.full ? ST_FULL : ST_ADDED;
            res_idx    = ch_idx[ROUTE_ENTRIES];
        end else if (tail.found) begin
            res_status = ST_FOUND;
            res_hop    = ch_hop[ROUTE_ENTRIES];
            res_iface  = ch_iface[ROUTE_ENTRIES];
            res_idx    = ch_idx[ROUTE_ENTRIES];
        end else if (def_valid_reg) begin
            res_status = ST_FOUND;
            res_hop    = (def_gw_reg != '0) ? def_gw_reg : ch_addr[ROUTE_ENTRIES];
            res_iface  = def_iface_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_status_reg <= res_status;
            m_hop_reg    <= res_hop;
            m_iface_reg  <= res_iface;
            m_idx_reg    <= res_idx;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = M_TDATA_W'({m_idx_reg, m_iface_reg, m_hop_reg});

    // A token reaches the end of the row only while an item is in flight
    a_tail_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        tail.valid |-> busy_reg)
        else $error("token at row end with no item in flight");

    // The table never holds more routes than it has cells
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= ENTRIES_IDX)
        else $error("route count beyond table size");

    // An accepted add with room grows the table by exactly one
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && is_add && !full) |=> count_reg == $past(count_reg) + IDX_W'(1))
        else $error("route count did not advance on add");

    // A new result appears only when an item was in flight
    a_result_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> busy_reg)
        else $error("result loaded with no item in flight");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
module tb_top;
    import iprt_pkg::*;

    localparam int ROUTE_ENTRIES   = 16;
    localparam int RT_IDX_W        = $clog2(ROUTE_ENTRIES);
    localparam int HIT_W           = $clog2(ROUTE_ENTRIES + 1);
    localparam int M_TDATA_W       = ((ADDR_W + IFACE_W + HIT_W + 7) / 8) * 8;
    localparam int HIT_NONE        = ROUTE_ENTRIES;
    localparam int PLAN_ROWS       = 31;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 104;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int MAX_REPORTS     = 10;

    // Index with no register behind it; writes to it must leave everything alone
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct packed {
        logic               action;
        logic [ADDR_W-1:0]  net;
        logic [ADDR_W-1:0]  mask;
        logic [ADDR_W-1:0]  gw;
        logic [IFACE_W-1:0] iface;
        logic [ADDR_W-1:0]  addr;
    } route_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  net;
        logic [ADDR_W-1:0]  mask;
        logic [ADDR_W-1:0]  gw;
        logic [IFACE_W-1:0] iface;
    } route_entry_t;

    typedef struct packed {
        status_t            status;
        logic [ADDR_W-1:0]  next_hop;
        logic [IFACE_W-1:0] out_iface;
        logic [HIT_W-1:0]   hit_index;
    } route_decision_t;

    typedef struct packed {
        row_kind_e              kind;
        route_item_t            it;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        logic                   typed;
        route_decision_t        want;
    } plan_row_t;

    // Clock, reset and every DUT input start at known values
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = ACT_ADD;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [1:0]             m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Shadow of the route table and the default route registers
    route_entry_t           routes [ROUTE_ENTRIES];
    int unsigned            route_count = 0;
    logic                   dflt_valid  = 1'b0;
    logic [ADDR_W-1:0]      dflt_gw     = '0;
    logic [IFACE_W-1:0]     dflt_iface  = '0;

    route_decision_t        expected_decisions [$];
    plan_row_t              plan [PLAN_ROWS];
    int unsigned            mismatch_count = 0;
    int unsigned            cycle_count    = 0;
    int unsigned            ready_hold     = 0;
    logic                   steady         = 1'b0;

    ipv4_route_table_lookup #(
        .ROUTE_ENTRIES(ROUTE_ENTRIES)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: apply one item to the shadow table and return the
    // decision the block should hand back for it.
    // ------------------------------------------------------------------
    function automatic route_decision_t resolve_route(route_item_t it);
        route_decision_t res;
        logic            hit;
        res.status    = ST_UNREACH;
        res.next_hop  = '0;
        res.out_iface = '0;
        res.hit_index = HIT_W'(HIT_NONE);
        hit           = 1'b0;
        if (it.action == ACT_ADD) begin
            // Refuse the add once every slot is taken; nothing else changes
            if (route_count >= ROUTE_ENTRIES) begin
                res.status = ST_FULL;
            end else begin
                routes[RT_IDX_W'(route_count)] = '{it.net, it.mask, it.gw, it.iface};
                res.status          = ST_ADDED;
                res.hit_index       = HIT_W'(route_count);
                route_count++;
            end
            return res;
        end
        // First match in insertion order wins
        for (int unsigned i = 0; i < route_count; i++) begin
            if (!hit && ((it.addr & routes[RT_IDX_W'(i)].mask) ==
                         routes[RT_IDX_W'(i)].net)) begin
                hit           = 1'b1;
                res.status    = ST_FOUND;
                res.next_hop  = (routes[RT_IDX_W'(i)].gw != '0) ? routes[RT_IDX_W'(i)].gw
                                                                 : it.addr;
                res.out_iface = routes[RT_IDX_W'(i)].iface;
                res.hit_index = HIT_W'(i);
            end
        end
        // Fall back on the default route, which reports no table slot
        if (!hit && dflt_valid) begin
            res.status    = ST_FOUND;
            res.next_hop  = (dflt_gw != '0) ? dflt_gw : it.addr;
            res.out_iface = dflt_iface;
        end
        return res;
    endfunction

    function automatic route_item_t make_item(logic action, logic [31:0] net,
                                              logic [31:0] mask, logic [31:0] gw,
                                              logic [2:0] iface, logic [31:0] addr);
        route_item_t it;
        it = '{action, net, mask, gw, iface, addr};
        return it;
    endfunction

    function automatic plan_row_t item_row(route_item_t it, logic typed,
                                           status_t status, int hit);
        plan_row_t row;
        row         = '0;
        row.kind    = ROW_ITEM;
        row.it      = it;
        row.typed   = typed;
        row.want    = '{status, '0, '0, HIT_W'(hit)};
        return row;
    endfunction

    function automatic plan_row_t add_row(logic [31:0] net, logic [31:0] mask,
                                          logic [31:0] gw, logic [2:0] iface, int slot);
        return item_row(make_item(ACT_ADD, net, mask, gw, iface, '0), 1'b1, ST_ADDED, slot);
    endfunction

    function automatic plan_row_t look_row(logic [31:0] addr);
        return item_row(make_item(ACT_LOOKUP, '0, '0, '0, '0, addr), 1'b0, ST_UNREACH, 0);
    endfunction

    function automatic plan_row_t cfg_row(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
        plan_row_t row;
        row         = '0;
        row.kind    = ROW_CFG;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    // Mostly back-to-back or short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Random item: a few refused adds, many lookups aimed inside a held
    // route (random host bits), the rest arbitrary or extreme addresses.
    function automatic route_item_t random_item();
        route_item_t it;
        int unsigned roll;
        int unsigned k;
        roll = $urandom_range(0, 99);
        it   = make_item(ACT_LOOKUP, $urandom, $urandom, $urandom,
                         IFACE_W'($urandom_range(0, 7)), $urandom);
        if (roll < 10) begin
            it.action = ACT_ADD;
        end else if (roll < 60 && route_count != 0) begin
            k       = $urandom_range(0, route_count - 1);
            it.addr = (routes[RT_IDX_W'(k)].net & routes[RT_IDX_W'(k)].mask) |
                      ($urandom & ~routes[RT_IDX_W'(k)].mask);
        end else if (roll < 64) begin
            it.addr = (roll[0]) ? 32'hFFFF_FFFF : 32'h0000_0000;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Present one item, hold it until the transaction completes, then
    // queue the decision that must come back for it.
    task automatic send_item(route_item_t it, logic typed, route_decision_t want);
        logic [S_TDATA_W-1:0] word;
        route_decision_t      guess;
        int unsigned          gap;
        word                           = '0;
        word[S_NET_LSB   +: ADDR_W]    = it.net;
        word[S_MASK_LSB  +: ADDR_W]    = it.mask;
        word[S_GW_LSB    +: ADDR_W]    = it.gw;
        word[S_IFACE_LSB +: IFACE_W]   = it.iface;
        word[S_ADDR_LSB  +: ADDR_W]    = it.addr;
        cfg_valid <= 1'b0;
        s_tvalid  <= 1'b1;
        s_tuser   <= it.action;
        s_tdata   <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        guess = resolve_route(it);
        expected_decisions.push_back(typed ? want : guess);
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Write one register; valid stays up so that writes can run back to back
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_DEFAULT_VALID: dflt_valid = val[0];
            CFG_DEFAULT_GW:    dflt_gw    = val[ADDR_W-1:0];
            CFG_DEFAULT_IFACE: dflt_iface = val[IFACE_W-1:0];
            default: ;
        endcase
    endtask

    // Stop sending and hold until every queued decision has come back.
    // Sample the queue at the falling edge, clear of the monitor's update.
    task automatic wait_idle();
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        do @(negedge aclk); while (expected_decisions.size() != 0);
        @(posedge aclk);
    endtask

    // Receiver: random stalls, mostly short, a few long; none while steady
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            ready_hold <= 0;
        end else if (steady) begin
            m_tready   <= 1'b1;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 99) < 35) begin
            m_tready   <= 1'b0;
            ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
        end else begin
            m_tready   <= 1'b1;
            ready_hold <= $urandom_range(0, 12);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare every result transaction with the oldest
    // queued decision, field by field.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        route_decision_t got;
        route_decision_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status    = status_t'(m_tuser);
            got.next_hop  = m_tdata[0 +: ADDR_W];
            got.out_iface = m_tdata[ADDR_W +: IFACE_W];
            got.hit_index = m_tdata[ADDR_W + IFACE_W +: HIT_W];
            if (expected_decisions.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected route result: status=%0d hop=%h iface=%0d hit=%0d",
                             got.status, got.next_hop, got.out_iface, got.hit_index);
            end else begin
                want = expected_decisions.pop_front();
                if (got.status !== want.status || got.next_hop !== want.next_hop ||
                    got.out_iface !== want.out_iface || got.hit_index !== want.hit_index) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("route mismatch: want status=%0d hop=%h iface=%0d hit=%0d",
                                 want.status, want.next_hop, want.out_iface, want.hit_index);
                        $display("                got  status=%0d hop=%h iface=%0d hit=%0d",
                                 got.status, got.next_hop, got.out_iface, got.hit_index);
                    end
                end
            end
        end
    end

    // Watchdog: end a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        // Directed part: lookup on an empty table, fill all slots with
        // extreme and awkward routes, overflow the table, then lookups with
        // the default route off, on with a direct hop, and on via a gateway.
        plan = '{
            item_row(make_item(ACT_LOOKUP, '0, '0, '0, '0, 32'hFFFF_FFFF),
                     1'b1, ST_UNREACH, HIT_NONE),
            add_row(32'h0A00_0000, 32'hFF00_0000, 32'h0000_0000, 3'd0, 0),
            add_row(32'hC0A8_0100, 32'hFFFF_FF00, 32'hC0A8_0101, 3'd7, 1),
            // host route, every bit set
            add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 2),
            // network bit outside an empty mask: can never match
            add_row(32'h0000_0001, 32'h0000_0000, 32'h1234_5678, 3'd3, 3),
            // shadowed by the 10/8 route ahead of it
            add_row(32'h0A01_0000, 32'hFFFF_0000, 32'h0A00_00FE, 3'd1, 4),
            // holes in the mask
            add_row(32'h00FF_00FF, 32'h00FF_00FF, 32'h8000_0001, 3'd5, 5),
            add_row(32'hAC10_0000, 32'hFFF0_0000, 32'h0000_0000, 3'd2, 6),
            add_row(32'h6440_0000, 32'hFFC0_0000, 32'h6440_0001, 3'd4, 7),
            add_row(32'hC612_0000, 32'hFFFE_0000, 32'h0000_0000, 3'd6, 8),
            add_row(32'h0000_0002, 32'hAAAA_AAAA, 32'h5555_5555, 3'd6, 9),
            add_row(32'h0808_0808, 32'hFFFF_FFFF, 32'h0808_0801, 3'd3, 10),
            add_row(32'h7F00_0000, 32'hFF00_0000, 32'h0000_0000, 3'd0, 11),
            add_row(32'hE000_0000, 32'hF000_0000, 32'hE000_0001, 3'd5, 12),
            add_row(32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 3'd2, 13),
            add_row(32'h0102_0300, 32'hFFFF_FF00, 32'hFFFF_FFFE, 3'd1, 14),
            add_row(32'h0000_0000, 32'hFFFF_FFFF, 32'h0A0A_0A0A, 3'd4, 15),
            // table full: refuse and leave everything as it was
            item_row(make_item(ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               3'd7, '0), 1'b1, ST_FULL, HIT_NONE),
            look_row(32'h0A01_0203),
            look_row(32'hC0A8_01FE),
            look_row(32'hFFFF_FFFF),
            look_row(32'h1234_5678),
            cfg_row(CFG_DEFAULT_VALID, 32'd1),
            cfg_row(CFG_DEFAULT_IFACE, 32'd7),
            look_row(32'h1234_5678),
            cfg_row(CFG_DEFAULT_GW, 32'hFFFF_FFFF),
            look_row(32'h0000_0000),
            look_row(32'h0102_0304),
            cfg_row(CFG_SPARE, 32'hDEAD_BEEF),
            look_row(32'h0000_0010),
            cfg_row(CFG_DEFAULT_VALID, 32'd0)
        };

        // Hold reset at the start, then release it for good
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_CFG) begin
                wait_idle();
                write_reg(plan[r].reg_idx, plan[r].reg_val);
            end else begin
                send_item(plan[r].it, plan[r].typed, plan[r].want);
            end
        end

        // Random part: each phase drains the block, sets the default route,
        // pokes the spare index, then streams random items. Phase two runs
        // with no idling on either side.
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            steady <= (phase == 2);
            case (phase)
                0: begin
                    write_reg(CFG_DEFAULT_VALID, 32'd0);
                    write_reg(CFG_DEFAULT_GW, $urandom);
                    write_reg(CFG_DEFAULT_IFACE, $urandom_range(0, 7));
                end
                1: begin
                    write_reg(CFG_DEFAULT_VALID, 32'd1);
                    write_reg(CFG_DEFAULT_GW, 32'h0000_0000);
                    write_reg(CFG_DEFAULT_IFACE, 32'd0);
                end
                2: begin
                    write_reg(CFG_DEFAULT_VALID, 32'hFFFF_FFFF);
                    write_reg(CFG_DEFAULT_GW, 32'hFFFF_FFFF);
                    write_reg(CFG_DEFAULT_IFACE, 32'hFFFF_FFFF);
                end
                default: begin
                    // full random words: only the low bits of each register count
                    write_reg(CFG_DEFAULT_VALID, $urandom);
                    write_reg(CFG_DEFAULT_GW, ($urandom_range(0, 3) == 0) ? '0 : $urandom);
                    write_reg(CFG_DEFAULT_IFACE, $urandom);
                end
            endcase
            write_reg(CFG_SPARE, $urandom);
            repeat (ITEMS_PER_PHASE) send_item(random_item(), 1'b0, '0);
        end

        // Drain, then give any stray result time to show up
        wait_idle();
        repeat (2 * (ROUTE_ENTRIES + 1)) @(posedge aclk);
        if (mismatch_count == 0 && expected_decisions.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
hdl/iprt_pkg.sv
hdl/iprt_cell.sv
hdl/ipv4_route_table_lookup.sv
dv/tb_top.sv
